/* rtl/ilfl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilfl_pkg
// Shared types and constants for the indexed list with free list: word
// formats, opcode and status codes, microcode control word and flags.
// ----------------------------------------------------------------------------
package ilfl_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;

  // slot address and link width (a link also codes "none" as CAPACITY)
  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);

  localparam int OPC_W   = 2;
  localparam int IDX_W   = 7;
  localparam int DATA_W  = 32;
  localparam int RSLOT_W = 6;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 7;
  localparam int CMP_W   = (LW > IDX_W) ? LW : IDX_W;

  localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPC_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OPC_W-1:0] OP_GET    = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd3;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [IDX_W-1:0]  slot_index;
    logic [DATA_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [RSLOT_W-1:0] result_slot;
    logic [DATA_W-1:0]  read_value;
    logic [STAT_W-1:0]  status;
    logic [CNT_W-1:0]   entry_count;
  } rsp_t;

  // microprogram steps; fall-through order matters
  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE0,
    S_DECODE1,
    S_DECODE2,
    S_BADOP,
    S_INS0,
    S_INS1,
    S_INSFULL,
    S_DEL0,
    S_DEL1,
    S_DEL2,
    S_DEL3,
    S_DEL4,
    S_DEL5,
    S_NOTFOUND,
    S_UNLINK,
    S_PUSHFREE,
    S_DELHEAD,
    S_GET0,
    S_GET1,
    S_GET2,
    S_FINISH
  } step_e;

  localparam int STEP_W = 5;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_OP_INS,
    C_OP_DEL,
    C_OP_GET,
    C_FULL,
    C_IDX_OOR,
    C_EMPTY,
    C_HEAD_HIT,
    C_WALK_GO,
    C_NXT_HIT
  } cond_e;

  typedef enum logic [1:0] {
    LA_FREE,
    LA_IDX,
    LA_CUR,
    LA_NXT
  } lra_e;

  typedef enum logic [1:0] {
    WA_FREE,
    WA_IDX,
    WA_CUR
  } lwa_e;

  typedef enum logic [1:0] {
    WD_USED,
    WD_FREE,
    WD_SKIP
  } lwd_e;

  typedef struct packed {
    cond_e             cond;
    step_e             target;
    logic              lrd;         // link store read
    lra_e              lra;
    logic              lwr;         // link store write
    lwa_e              lwa;
    lwd_e              lwd;
    logic              vrd;         // value store read at slot_index
    logic              vwr;         // value store write at free head
    logic              ins_commit;
    logic              head_commit;
    logic              free_push;
    logic              walk_init;
    logic              walk_adv;
    logic              ld_skip;
    logic              ld_rval;
    logic              set_st;
    logic [STAT_W-1:0] st;
    logic              done;
  } ctrl_t;

  typedef struct packed {
    logic op_ins;
    logic op_del;
    logic op_get;
    logic full;
    logic idx_oor;
    logic empty;
    logic head_hit;
    logic walk_go;
    logic nxt_hit;
  } flags_t;

endpackage

/* rtl/ilfl_useq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilfl_useq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module ilfl_useq import ilfl_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  flags_t flags_i,
  output ctrl_t  ctrl_o,
  output logic   busy_o
);

  step_e pc_q, pc_d;
  ctrl_t word;
  logic  taken;

  function automatic ctrl_t ucode(input step_e s);
    ctrl_t c;
    c = '0;
    case (s)
      S_DECODE0: begin
        c.cond = C_OP_INS; c.target = S_INS0;
      end
      S_DECODE1: begin
        c.cond = C_OP_DEL; c.target = S_DEL0;
      end
      S_DECODE2: begin
        c.cond = C_OP_GET; c.target = S_GET0;
      end
      S_BADOP: begin
        c.set_st = 1'b1; c.st = ST_RANGE;
        c.cond = C_ALWAYS; c.target = S_FINISH;
      end
      S_INS0: begin
        c.lrd = 1'b1; c.lra = LA_FREE;
        c.cond = C_FULL; c.target = S_INSFULL;
      end
      S_INS1: begin
        c.vwr = 1'b1;
        c.lwr = 1'b1; c.lwa = WA_FREE; c.lwd = WD_USED;
        c.ins_commit = 1'b1;
        c.set_st = 1'b1; c.st = ST_OK;
        c.cond = C_ALWAYS; c.target = S_FINISH;
      end
      S_INSFULL: begin
        c.set_st = 1'b1; c.st = ST_FULL;
        c.cond = C_ALWAYS; c.target = S_FINISH;
      end
      S_DEL0: begin
        c.cond = C_IDX_OOR; c.target = S_BADOP;
      end
      S_DEL1: begin
        c.cond = C_EMPTY; c.target = S_NOTFOUND;
      end
      S_DEL2: begin
        c.lrd = 1'b1; c.lra = LA_IDX;
        c.walk_init = 1'b1;
        c.cond = C_HEAD_HIT; c.target = S_DELHEAD;
      end
      S_DEL3: begin
        c.ld_skip = 1'b1;
        c.lrd = 1'b1; c.lra = LA_CUR;
      end
      S_DEL4: begin
        c.walk_adv = 1'b1;
        c.lrd = 1'b1; c.lra = LA_NXT;
        c.cond = C_WALK_GO; c.target = S_DEL4;
      end
      S_DEL5: begin
        c.cond = C_NXT_HIT; c.target = S_UNLINK;
      end
      S_NOTFOUND: begin
        c.set_st = 1'b1; c.st = ST_NOTFOUND;
        c.cond = C_ALWAYS; c.target = S_FINISH;
      end
      S_UNLINK: begin
        c.lwr = 1'b1; c.lwa = WA_CUR; c.lwd = WD_SKIP;
      end
      S_PUSHFREE: begin
        c.lwr = 1'b1; c.lwa = WA_IDX; c.lwd = WD_FREE;
        c.free_push = 1'b1;
        c.set_st = 1'b1; c.st = ST_OK;
        c.cond = C_ALWAYS; c.target = S_FINISH;
      end
      S_DELHEAD: begin
        c.head_commit = 1'b1;
        c.lwr = 1'b1; c.lwa = WA_IDX; c.lwd = WD_FREE;
        c.free_push = 1'b1;
        c.set_st = 1'b1; c.st = ST_OK;
        c.cond = C_ALWAYS; c.target = S_FINISH;
      end
      S_GET0: begin
        c.cond = C_IDX_OOR; c.target = S_BADOP;
      end
      S_GET1: begin
        c.vrd = 1'b1;
      end
      S_GET2: begin
        c.ld_rval = 1'b1;
        c.set_st = 1'b1; c.st = ST_OK;
        c.cond = C_ALWAYS; c.target = S_FINISH;
      end
      S_FINISH: begin
        c.done = 1'b1;
        c.cond = C_ALWAYS; c.target = S_IDLE;
      end
      default: begin
        c = '0;
      end
    endcase
    return c;
  endfunction

  assign word = ucode(pc_q);

  always_comb begin
    case (word.cond)
      C_NONE:     taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_OP_INS:   taken = flags_i.op_ins;
      C_OP_DEL:   taken = flags_i.op_del;
      C_OP_GET:   taken = flags_i.op_get;
      C_FULL:     taken = flags_i.full;
      C_IDX_OOR:  taken = flags_i.idx_oor;
      C_EMPTY:    taken = flags_i.empty;
      C_HEAD_HIT: taken = flags_i.head_hit;
      C_WALK_GO:  taken = flags_i.walk_go;
      C_NXT_HIT:  taken = flags_i.nxt_hit;
      default:    taken = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (pc_q == S_IDLE) begin
      pc_d = start_i ? S_DECODE0 : S_IDLE;
    end else if (taken) begin
      pc_d = word.target;
    end else begin
      pc_d = step_e'(STEP_W'(pc_q) + STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  // walk advance and its read only happen when the walk continues
  always_comb begin
    ctrl_o = word;
    if (word.walk_adv && !taken) begin
      ctrl_o.walk_adv = 1'b0;
      ctrl_o.lrd      = 1'b0;
    end
    busy_o = (pc_q != S_IDLE);
  end

endmodule

/* rtl/indexed_list_with_free_list_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_with_free_list_core
// Slot table with a used chain and a free chain threaded through a link store.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; every word gives exactly
// one result, shown for one cycle with done_o, and the receiver cannot stall
// it. Work runs as a microprogram over single-ported link and value stores
// with registered reads. A delete of a slot other than the head walks the
// used chain, one link-store read per cycle, up to the slot before it or the
// chain's end, so that word takes longest. busy drops in the cycle done_o
// shows, so the next word can be taken then. After reset the block is ready
// at once (no clearing pass; per-entry valid bits supply the reset contents).
// ----------------------------------------------------------------------------
module indexed_list_with_free_list_core import ilfl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  ctrl_t  ctrl;
  flags_t flags;
  logic   accept;

  // captured word
  logic [OPC_W-1:0]  op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [DATA_W-1:0] item_q;
  logic [AW-1:0]     idx_a;

  // list state
  logic [LW-1:0] used_head_q, free_head_q, count_q;
  logic [LW-1:0] cur_q, skip_q;
  logic [AW-1:0] steps_q;

  // result staging
  logic [RSLOT_W-1:0] rslot_q;
  logic [DATA_W-1:0]  rval_q;
  logic [STAT_W-1:0]  status_q;
  logic               done_q;
  rsp_t               rsp_q;

  // stores
  logic [LW-1:0]          link_mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] val_mem  [CAPACITY];
  logic [CAPACITY-1:0]    link_vld_q, val_vld_q;
  logic [LW-1:0]          link_mem_q;
  logic [AW-1:0]          link_addr_q;
  logic                   link_vld_rd_q;
  logic [VALUE_WIDTH-1:0] val_mem_q;
  logic                   val_vld_rd_q;
  logic [LW-1:0]          link_rd;
  logic [VALUE_WIDTH-1:0] val_rd;
  logic [AW-1:0]          lra, lwa;
  logic [LW-1:0]          lwd;
  logic [AW-1:0]          free_a;

  assign accept = start & ~busy;
  assign idx_a  = idx_q[AW-1:0];
  assign free_a = free_head_q[AW-1:0];

  ilfl_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  // unwritten link entry i reads as i+1 (the last one as none)
  assign link_rd = link_vld_rd_q ? link_mem_q : (LW'(link_addr_q) + LW'(1));
  assign val_rd  = val_vld_rd_q ? val_mem_q : '0;

  always_comb begin
    case (ctrl.lra)
      LA_FREE: lra = free_a;
      LA_IDX:  lra = idx_a;
      LA_CUR:  lra = cur_q[AW-1:0];
      LA_NXT:  lra = link_rd[AW-1:0];
      default: lra = idx_a;
    endcase
    case (ctrl.lwa)
      WA_FREE: lwa = free_a;
      WA_IDX:  lwa = idx_a;
      WA_CUR:  lwa = cur_q[AW-1:0];
      default: lwa = idx_a;
    endcase
    case (ctrl.lwd)
      WD_USED: lwd = used_head_q;
      WD_FREE: lwd = free_head_q;
      WD_SKIP: lwd = skip_q;
      default: lwd = free_head_q;
    endcase
  end

  always_comb begin
    flags.op_ins   = (op_q == OP_INSERT);
    flags.op_del   = (op_q == OP_DELETE);
    flags.op_get   = (op_q == OP_GET);
    flags.full     = (count_q >= LW'(CAPACITY)) || (free_head_q >= LW'(CAPACITY));
    flags.idx_oor  = (idx_q >= IDX_W'(CAPACITY));
    flags.empty    = (count_q == '0) || (used_head_q >= LW'(CAPACITY));
    flags.head_hit = (CMP_W'(used_head_q) == CMP_W'(idx_q));
    flags.nxt_hit  = (CMP_W'(link_rd) == CMP_W'(idx_q));
    flags.walk_go  = !flags.nxt_hit && (link_rd < LW'(CAPACITY)) &&
                     (steps_q != AW'(CAPACITY - 1));
  end

  // link store
  always_ff @(posedge clk_i) begin
    if (ctrl.lrd) begin
      link_mem_q    <= link_mem[lra];
      link_addr_q   <= lra;
      link_vld_rd_q <= link_vld_q[lra];
    end
    if (ctrl.lwr) begin
      link_mem[lwa] <= lwd;
    end
  end

  // value store
  always_ff @(posedge clk_i) begin
    if (ctrl.vrd) begin
      val_mem_q    <= val_mem[idx_a];
      val_vld_rd_q <= val_vld_q[idx_a];
    end
    if (ctrl.vwr) begin
      val_mem[free_a] <= item_q[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
      val_vld_q  <= '0;
    end else begin
      if (ctrl.lwr) begin
        link_vld_q[lwa] <= 1'b1;
      end
      if (ctrl.vwr) begin
        val_vld_q[free_a] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_head_q <= LW'(CAPACITY);
      free_head_q <= '0;
      count_q     <= '0;
    end else begin
      if (ctrl.ins_commit) begin
        used_head_q <= free_head_q;
        free_head_q <= link_rd;
        count_q     <= count_q + LW'(1);
      end
      if (ctrl.head_commit) begin
        used_head_q <= link_rd;
      end
      if (ctrl.free_push) begin
        free_head_q <= LW'(idx_a);
        count_q     <= count_q - LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= req_i.opcode;
      idx_q    <= req_i.slot_index;
      item_q   <= req_i.item_value;
      rslot_q  <= req_i.slot_index[RSLOT_W-1:0];
      rval_q   <= '0;
      status_q <= ST_OK;
    end
    if (ctrl.ins_commit) begin
      rslot_q <= RSLOT_W'(free_a);
    end
    if (ctrl.walk_init) begin
      cur_q   <= used_head_q;
      steps_q <= '0;
    end
    if (ctrl.walk_adv) begin
      cur_q   <= link_rd;
      steps_q <= steps_q + AW'(1);
    end
    if (ctrl.ld_skip) begin
      skip_q <= link_rd;
    end
    if (ctrl.ld_rval) begin
      rval_q <= DATA_W'(val_rd);
    end
    if (ctrl.set_st) begin
      status_q <= ctrl.st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.done) begin
      rsp_q.result_slot <= rslot_q;
      rsp_q.read_value  <= rval_q;
      rsp_q.status      <= status_q;
      rsp_q.entry_count <= CNT_W'(count_q);
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

/* rtl/ilfl_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilfl_chk
// Port-level checks for the indexed list core, bound to the top level.
// ----------------------------------------------------------------------------
module ilfl_chk import ilfl_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic done_o,
  input rsp_t rsp_o
);

  // a taken word keeps the block busy for at least the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // one result per word: never two strobes back to back
  a_single_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // only a successful get carries a value
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_OK) |-> (rsp_o.read_value == '0))
    else $error("read value nonzero on failed word");

  // full is reported only when every slot is in use
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_FULL) |-> (rsp_o.entry_count == CNT_W'(CAPACITY)))
    else $error("full status with free slots left");

endmodule

bind indexed_list_with_free_list_core ilfl_chk u_ilfl_chk (.*);
